// ===== rtl/core/escape_stuffed_frame_receiver_assert.svh =====
// assertion macros used by the frame receiver decode module
`ifndef ESCAPE_STUFFED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPE_STUFFED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ESFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ESFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/esfr_pkg.sv =====
// types, constants and register indexes of the escape-stuffed frame receiver
package esfr_pkg;

    // payload room of one frame
    localparam int BUFFER_BYTES = 128;
    localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);

    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESCAPE         = 3'd0,
        CFG_START_HBUS     = 3'd1,
        CFG_START_MQTT     = 3'd2,
        CFG_START_HBUS_ENC = 3'd3,
        CFG_START_MQTT_ENC = 3'd4,
        CFG_END            = 3'd5,
        CFG_SINGLE_ESC     = 3'd6,
        CFG_DOUBLE_ESC     = 3'd7
    } t_cfg_idx;

    // reset values of the code registers
    localparam logic [7:0] RST_ESCAPE         = 8'd27;
    localparam logic [7:0] RST_START_HBUS     = 8'd2;
    localparam logic [7:0] RST_START_MQTT     = 8'd3;
    localparam logic [7:0] RST_START_HBUS_ENC = 8'd4;
    localparam logic [7:0] RST_START_MQTT_ENC = 8'd5;
    localparam logic [7:0] RST_END            = 8'd7;
    localparam logic [7:0] RST_SINGLE_ESC     = 8'd1;
    localparam logic [7:0] RST_DOUBLE_ESC     = 8'd6;

    typedef struct packed {
        logic [7:0] escape_code;
        logic [7:0] start_hbus_code;
        logic [7:0] start_mqtt_code;
        logic [7:0] start_hbus_enc_code;
        logic [7:0] start_mqtt_enc_code;
        logic [7:0] end_code;
        logic [7:0] single_escape_code;
        logic [7:0] double_escape_code;
    } t_cfg;

    // one result beat
    typedef struct packed {
        logic [1:0]  byte_count;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [6:0]  first_position;
        logic        frame_done;
        logic [7:0]  frame_length;
        logic        is_native_frame;
        logic        is_encrypted;
        logic        in_frame;
        logic [15:0] error_count;
    } t_result;

endpackage

// ===== rtl/core/esfr_cfg_regs.sv =====
// code registers written through the configuration port
module esfr_cfg_regs
    import esfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register select
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ESCAPE:         n_cfg.escape_code         = i_cfg_wdata;
                CFG_START_HBUS:     n_cfg.start_hbus_code     = i_cfg_wdata;
                CFG_START_MQTT:     n_cfg.start_mqtt_code     = i_cfg_wdata;
                CFG_START_HBUS_ENC: n_cfg.start_hbus_enc_code = i_cfg_wdata;
                CFG_START_MQTT_ENC: n_cfg.start_mqtt_enc_code = i_cfg_wdata;
                CFG_END:            n_cfg.end_code            = i_cfg_wdata;
                CFG_SINGLE_ESC:     n_cfg.single_escape_code  = i_cfg_wdata;
                CFG_DOUBLE_ESC:     n_cfg.double_escape_code  = i_cfg_wdata;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // register file with reset codes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_code         <= RST_ESCAPE;
            r_cfg.start_hbus_code     <= RST_START_HBUS;
            r_cfg.start_mqtt_code     <= RST_START_MQTT;
            r_cfg.start_hbus_enc_code <= RST_START_HBUS_ENC;
            r_cfg.start_mqtt_enc_code <= RST_START_MQTT_ENC;
            r_cfg.end_code            <= RST_END;
            r_cfg.single_escape_code  <= RST_SINGLE_ESC;
            r_cfg.double_escape_code  <= RST_DOUBLE_ESC;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/esfr_decode.sv =====
// framing state and per-byte escape decode
module esfr_decode
    import esfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

`include "escape_stuffed_frame_receiver_assert.svh"

    logic             r_esc_pending;
    logic             r_open;
    logic [LEN_W-1:0] r_len;
    logic             r_native;
    logic             r_enc;
    logic [15:0]      r_errors;

    logic             n_esc_pending;
    logic             n_open;
    logic [LEN_W-1:0] n_len;
    logic             n_native;
    logic             n_enc;
    logic [15:0]      n_errors;

    logic             full;
    logic             hit_hbus;
    logic             hit_mqtt;
    logic             hit_hbus_enc;
    logic             hit_mqtt_enc;
    logic [LEN_W-1:0] len_inc;
    logic [1:0]       count;
    logic [7:0]       first;
    logic [7:0]       second;
    logic             done;

    assign full         = (r_len >= LEN_W'(BUFFER_BYTES));
    assign hit_hbus     = (i_byte == i_cfg.start_hbus_code);
    assign hit_mqtt     = (i_byte == i_cfg.start_mqtt_code);
    assign hit_hbus_enc = (i_byte == i_cfg.start_hbus_enc_code);
    assign hit_mqtt_enc = (i_byte == i_cfg.start_mqtt_enc_code);
    assign len_inc      = r_len + LEN_W'(1);

    // decode of one byte against the current framing state
    always_comb begin
        n_esc_pending = r_esc_pending;
        n_open        = r_open;
        n_len         = r_len;
        n_native      = r_native;
        n_enc         = r_enc;
        n_errors      = r_errors;
        count         = 2'd0;
        first         = 8'd0;
        second        = 8'd0;
        done          = 1'b0;
        if (!full) begin
            if (r_esc_pending) begin
                n_esc_pending = 1'b0;
                if (hit_hbus || hit_mqtt || hit_hbus_enc || hit_mqtt_enc) begin
                    // start code, a start inside a frame is an error
                    if (r_open) begin
                        n_errors = r_errors + 16'd1;
                    end
                    n_open   = 1'b1;
                    n_len    = '0;
                    n_native = hit_hbus || hit_hbus_enc;
                    n_enc    = hit_hbus_enc || hit_mqtt_enc;
                end else if (i_byte == i_cfg.end_code) begin
                    if (!r_open) begin
                        n_errors = r_errors + 16'd1;
                    end else begin
                        done   = 1'b1;
                        n_open = 1'b0;
                    end
                end else if (i_byte == i_cfg.single_escape_code) begin
                    if (!r_open) begin
                        n_errors = r_errors + 16'd1;
                    end else begin
                        first = i_cfg.escape_code;
                        count = 2'd1;
                        n_len = len_inc;
                    end
                end else if (i_byte == i_cfg.double_escape_code) begin
                    if (!r_open) begin
                        n_errors = r_errors + 16'd1;
                    end else begin
                        first = i_cfg.escape_code;
                        count = 2'd1;
                        n_len = len_inc;
                        // second escape only if room is left
                        if (len_inc < LEN_W'(BUFFER_BYTES)) begin
                            second = i_cfg.escape_code;
                            count  = 2'd2;
                            n_len  = len_inc + LEN_W'(1);
                        end
                    end
                end else begin
                    n_errors = r_errors + 16'd1;
                end
            end else if (i_byte == i_cfg.escape_code) begin
                n_esc_pending = 1'b1;
            end else if (!r_open) begin
                n_errors = r_errors + 16'd1;
            end else begin
                first = i_byte;
                count = 2'd1;
                n_len = len_inc;
            end
        end
    end

    // result beat shows the state after this byte
    always_comb begin
        o_result.byte_count      = count;
        o_result.first_byte      = first;
        o_result.second_byte     = second;
        o_result.first_position  = (count != 2'd0) ? 7'(r_len) : 7'd0;
        o_result.frame_done      = done;
        o_result.frame_length    = 8'(n_len);
        o_result.is_native_frame = n_native;
        o_result.is_encrypted    = n_enc;
        o_result.in_frame        = n_open;
        o_result.error_count     = n_errors;
    end

    // framing state, moves once per decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pending <= 1'b0;
            r_open        <= 1'b0;
            r_len         <= '0;
            r_native      <= 1'b0;
            r_enc         <= 1'b0;
            r_errors      <= 16'd0;
        end else if (i_step) begin
            r_esc_pending <= n_esc_pending;
            r_open        <= n_open;
            r_len         <= n_len;
            r_native      <= n_native;
            r_enc         <= n_enc;
            r_errors      <= n_errors;
        end
    end

    // checks on the framing state
    `ESFR_ASSERT_NOW(a_len_bounded, 1'b1, r_len <= LEN_W'(BUFFER_BYTES), "length beyond capacity")
    `ESFR_ASSERT_NEXT(a_full_frozen, i_step && full, $stable(r_len) && $stable(r_errors) && $stable(r_esc_pending), "state moved while full")
    `ESFR_ASSERT_NEXT(a_done_closes, i_step && done, !r_open && $past(r_open), "done without an open frame")
    `ESFR_ASSERT_NOW(a_count_range, i_step, count != 2'd3 && (count != 2'd0 || n_len == r_len || n_len == '0), "bad byte count")

endmodule

// ===== rtl/core/escape_stuffed_frame_receiver.sv =====
// top level of the escape-stuffed frame receiver
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  input    | i_in_valid / o_in_ready   | i_rx_byte
//  result   | o_out_valid / i_out_ready | o_byte_count .. o_error_count
//  config   | i_cfg_wr_en               | i_cfg_index, i_cfg_wdata
//
// one byte per cycle sustained while results are taken; a byte sits in the
// input register, is decoded on its way to the result register, and its
// result shows there once the byte has moved on from the input register.
// the input register refills while a result waits, and stalls only when both
// the input and result registers are full and the result is not taken.
// reset (synchronous, active low) clears the framing state and reloads codes.
module escape_stuffed_frame_receiver
    import esfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_byte_count,
    output logic [7:0]           o_first_byte,
    output logic [7:0]           o_second_byte,
    output logic [6:0]           o_first_position,
    output logic                 o_frame_done,
    output logic [7:0]           o_frame_length,
    output logic                 o_is_native_frame,
    output logic                 o_is_encrypted,
    output logic                 o_in_frame,
    output logic [15:0]          o_error_count,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_wdata
);

    t_cfg    cfg;
    t_result dec_result;

    logic    r_in_valid;
    logic    [7:0] r_in_byte;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;

    // byte moves from input register to result register
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    esfr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    esfr_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (dec_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= dec_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_count      = r_out.byte_count;
    assign o_first_byte      = r_out.first_byte;
    assign o_second_byte     = r_out.second_byte;
    assign o_first_position  = r_out.first_position;
    assign o_frame_done      = r_out.frame_done;
    assign o_frame_length    = r_out.frame_length;
    assign o_is_native_frame = r_out.is_native_frame;
    assign o_is_encrypted    = r_out.is_encrypted;
    assign o_in_frame        = r_out.in_frame;
    assign o_error_count     = r_out.error_count;

endmodule
